// ----- src/lphi_pkg.sv -----
`timescale 1ns / 1ps
package lphi_pkg;

	// SLOTS must be a power of two: home slot and probe wrap use the low bits.
	localparam int unsigned SLOTS      = 16;
	localparam int unsigned SLOT_W     = $clog2(SLOTS);
	localparam int unsigned KEY_W      = 32;
	localparam int unsigned VAL_W      = 32;
	localparam int unsigned HASH_SHIFT = 16;
	localparam logic [KEY_W-1:0] HASH_MUL = 32'h045D_9F3B;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_LOOKUP = 1'b1
	} action_t;

	typedef struct packed {
		action_t             action;
		logic [KEY_W-1:0]    key;
		logic [VAL_W-1:0]    value;
		logic [SLOT_W-1:0]   home;
	} op_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_PROBE = 1'b1
	} probe_state_t;

endpackage

// ----- src/lphi_front.sv -----
`timescale 1ns / 1ps
module lphi_front
	import lphi_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic             action,
	input  logic [KEY_W-1:0] key,
	input  logic [VAL_W-1:0] value,
	input  logic             q_full,
	output logic             q_push,
	output op_t              q_op
);

	logic             s1_v_s1;
	action_t          action_s1;
	logic [KEY_W-1:0] key_s1;
	logic [VAL_W-1:0] value_s1;
	logic [KEY_W-1:0] mix_s1;

	logic             s2_v_s2;
	action_t          action_s2;
	logic [KEY_W-1:0] key_s2;
	logic [VAL_W-1:0] value_s2;
	logic [KEY_W-1:0] prod_s2;

	logic             s1_ready;
	logic             s2_ready;
	logic             accept;
	logic [KEY_W-1:0] folded;

	assign s2_ready = !s2_v_s2 || !q_full;
	assign s1_ready = !s1_v_s1 || s2_ready;
	assign full     = !s1_ready;
	assign accept   = push && s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_s1 <= 1'b0;
			s2_v_s2 <= 1'b0;
		end else begin
			if (s1_ready)
				s1_v_s1 <= accept;
			if (s2_ready)
				s2_v_s2 <= s1_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action_t'(action);
			key_s1    <= key;
			value_s1  <= value;
			mix_s1    <= key ^ (key >> HASH_SHIFT);
		end
		if (s2_ready && s1_v_s1) begin
			action_s2 <= action_s1;
			key_s2    <= key_s1;
			value_s2  <= value_s1;
			prod_s2   <= mix_s1 * HASH_MUL;
		end
	end

	assign folded = prod_s2 ^ (prod_s2 >> HASH_SHIFT);

	assign q_push = s2_v_s2 && !q_full;

	always_comb begin
		q_op.action = action_s2;
		q_op.key    = key_s2;
		q_op.value  = value_s2;
		q_op.home   = folded[SLOT_W-1:0];
	end

endmodule

// ----- src/lphi_fifo.sv -----
`timescale 1ns / 1ps
module lphi_fifo
	import lphi_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  op_t  wr_op,
	output logic q_full,
	input  logic rd_en,
	output op_t  rd_op,
	output logic q_empty
);

	op_t                entry_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign q_full  = count_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign q_empty = count_q == '0;
	assign rd_op   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			entry_q[wr_ptr_q] <= wr_op;
	end

endmodule

// ----- src/lphi_back.sv -----
`timescale 1ns / 1ps
module lphi_back
	import lphi_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  op_t              q_op,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output logic [VAL_W-1:0] read_value,
	output logic             found,
	output logic             dropped
);

	logic [KEY_W-1:0]  slot_key [SLOTS];
	logic [VAL_W-1:0]  slot_value [SLOTS];
	logic [SLOTS-1:0]  slot_used_q;

	probe_state_t      state_q;
	probe_state_t      state_next;
	op_t               op_q;
	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W-1:0] cnt_q;
	logic [KEY_W-1:0]  rkey_q;
	logic [VAL_W-1:0]  rval_q;

	logic              out_v_q;
	logic [VAL_W-1:0]  out_val_q;
	logic              out_found_q;
	logic              out_drop_q;

	logic [SLOT_W-1:0] rd_addr;
	logic              take;
	logic              stop;
	logic              finish;
	logic              wr_en;
	logic              used_now;
	logic              key_eq;

	assign used_now = slot_used_q[idx_q];
	assign key_eq   = rkey_q == op_q.key;
	// empty slot or same key ends the probe for both actions
	assign stop     = !used_now || key_eq;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE:  if (take)   state_next = ST_PROBE;
			ST_PROBE: if (finish) state_next = ST_IDLE;
			default:  state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		take    = 1'b0;
		finish  = 1'b0;
		wr_en   = 1'b0;
		rd_addr = idx_q + 1'b1;
		case (state_q)
			ST_IDLE: begin
				take    = !q_empty && !out_v_q;
				rd_addr = q_op.home;
			end
			ST_PROBE: begin
				finish = stop || (cnt_q == SLOT_W'(SLOTS - 1));
				wr_en  = stop && (op_q.action == ACT_INSERT);
			end
			default: ;
		endcase
	end

	assign q_pop = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_used_q <= '0;
			out_v_q     <= 1'b0;
		end else begin
			state_q <= state_next;
			if (wr_en)
				slot_used_q[idx_q] <= 1'b1;
			if (finish)
				out_v_q <= 1'b1;
			else if (pop)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rkey_q <= slot_key[rd_addr];
		rval_q <= slot_value[rd_addr];
		if (wr_en) begin
			slot_key[idx_q]   <= op_q.key;
			slot_value[idx_q] <= op_q.value;
		end
		if (take) begin
			op_q  <= q_op;
			idx_q <= q_op.home;
			cnt_q <= '0;
		end else if (state_q == ST_PROBE) begin
			idx_q <= idx_q + 1'b1;
			cnt_q <= cnt_q + 1'b1;
		end
		if (finish) begin
			if (op_q.action == ACT_INSERT) begin
				out_val_q   <= '0;
				out_found_q <= stop;
				out_drop_q  <= !stop;
			end else begin
				out_val_q   <= (used_now && key_eq) ? rval_q : '0;
				out_found_q <= used_now && key_eq;
				out_drop_q  <= 1'b0;
			end
		end
	end

	assign empty      = !out_v_q;
	assign read_value = out_val_q;
	assign found      = out_found_q;
	assign dropped    = out_drop_q;

endmodule

// ----- src/linear_probe_hash_index.sv -----
`timescale 1ns / 1ps
// Path: front stages s1 and s2, the queue, the back-end prober, its result register.
// The back prober handles one word at a time, at most SLOTS probes each, and takes
// the next word only while idle with its result register empty (popped).
// Reset: async active low; all slot used marks clear at once, no clearing pass.
// Front pipeline and 4-entry queue keep accepting while the back probes, until full.
module linear_probe_hash_index
	import lphi_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic             action,
	input  logic [KEY_W-1:0] key,
	input  logic [VAL_W-1:0] value,
	output logic             empty,
	input  logic             pop,
	output logic [VAL_W-1:0] read_value,
	output logic             found,
	output logic             dropped
);

	logic q_full;
	logic q_push;
	op_t  q_wr_op;
	logic q_pop;
	op_t  q_rd_op;
	logic q_empty;

	lphi_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.action (action),
		.key    (key),
		.value  (value),
		.q_full (q_full),
		.q_push (q_push),
		.q_op   (q_wr_op)
	);

	lphi_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_op   (q_wr_op),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_op   (q_rd_op),
		.q_empty (q_empty)
	);

	lphi_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_op       (q_rd_op),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.read_value (read_value),
		.found      (found),
		.dropped    (dropped)
	);

endmodule
